/* rtl/bqe_pkg.sv */
// Shared types and constants of the biquad cascade equalizer.
// No dependencies; every other file but bqe_ram uses it by scoped names.
package bqe_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int COEF_W       = 24;
    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int ACC_W        = PROD_W + 3;
    localparam int FRAC_W       = 20;
    localparam int TAPS         = 5;
    localparam int ADDR_W       = 7;
    localparam int LOCAL_ADDR_W = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_COEF_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_WORD    = 2'd1;

    localparam logic [2:0] TAP_B0 = 3'd0;
    localparam logic [2:0] TAP_B1 = 3'd1;
    localparam logic [2:0] TAP_B2 = 3'd2;
    localparam logic [2:0] TAP_A1 = 3'd3;
    localparam logic [2:0] TAP_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] COEF_ONE   = 24'sh100000;
    localparam int                       SAMPLE_MAX = 8388607;
    localparam int                       SAMPLE_MIN = -8388608;

    // word moved between sections
    typedef struct packed {
        logic                       chan;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip;
        logic                       bypass;
    } bqe_word_t;

    // coefficient write toward one section
    typedef struct packed {
        logic                     en;
        logic [LOCAL_ADDR_W-1:0]  addr;
        logic signed [COEF_W-1:0] data;
    } bqe_coef_wr_t;

endpackage

/* rtl/bqe_if.sv */
// Stream interfaces of the equalizer: sample words in, filtered words out.
// Depends on bqe_pkg for field widths.
interface bqe_in_if;
    logic                                valid;
    logic                                ready;
    logic                                channel_in;
    logic signed [bqe_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output channel_in, output sample_in, input ready);
    modport sink   (input valid, input channel_in, input sample_in, output ready);
endinterface

interface bqe_out_if;
    logic                                valid;
    logic                                ready;
    logic                                channel_out;
    logic signed [bqe_pkg::SAMPLE_W-1:0] sample_out;
    logic                                clipped;

    modport source (output valid, output channel_out, output sample_out, output clipped,
                    input ready);
    modport sink   (input valid, input channel_out, input sample_out, input clipped,
                    output ready);
endinterface

/* rtl/bqe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bqe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 10
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bqe_cell.sv */
// One biquad section for all channels: coefficient RAM, history and a shared MAC.
// Depends on bqe_pkg and bqe_ram.
module bqe_cell #(
    parameter int CHANNELS = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bqe_pkg::bqe_coef_wr_t coef_wr,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  bqe_pkg::bqe_word_t    in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bqe_pkg::bqe_word_t    out_word
);

    localparam int DEPTH = CHANNELS * bqe_pkg::TAPS;
    localparam int CA_W  = $clog2(DEPTH);
    localparam int CH_W  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int SW    = bqe_pkg::SAMPLE_W;
    localparam int YW    = bqe_pkg::ACC_W - bqe_pkg::FRAC_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [2:0] LAST_STEP = 3'd7;

    localparam logic signed [bqe_pkg::ACC_W-1:0] ROUND_HALF =
        bqe_pkg::ACC_W'(1) << (bqe_pkg::FRAC_W - 1);
    localparam logic signed [YW-1:0] Y_MAX = YW'(bqe_pkg::SAMPLE_MAX);
    localparam logic signed [YW-1:0] Y_MIN = YW'(bqe_pkg::SAMPLE_MIN);

    logic [1:0]         state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next;
    bqe_pkg::bqe_word_t item_reg;
    bqe_pkg::bqe_word_t out_reg;

    logic signed [SW-1:0] x1_reg [CHANNELS];
    logic signed [SW-1:0] x2_reg [CHANNELS];
    logic signed [SW-1:0] y1_reg [CHANNELS];
    logic signed [SW-1:0] y2_reg [CHANNELS];

    logic [DEPTH-1:0] coef_valid_reg;
    logic             cvalid_rd_reg;
    logic [2:0]       tap_mul_reg;

    logic signed [bqe_pkg::COEF_W-1:0] coef_rd;
    logic signed [bqe_pkg::COEF_W-1:0] coef_eff;
    logic signed [SW-1:0]              operand;
    logic signed [bqe_pkg::PROD_W-1:0] prod_next, prod_reg;
    logic                              neg_reg;
    logic signed [bqe_pkg::ACC_W-1:0]  acc_reg, acc_next, term;
    logic signed [bqe_pkg::ACC_W-1:0]  rnd;
    logic signed [YW-1:0]              y_wide;
    logic signed [SW-1:0]              y_sat;
    logic                              sat;

    logic [CH_W-1:0] ch_idx;
    logic [2:0]      rd_tap;
    logic [CA_W-1:0] raddr;
    logic            accept;
    logic            finish;

    assign ch_idx = CH_W'(item_reg.chan);
    assign rd_tap = (cnt_reg < 3'(bqe_pkg::TAPS)) ? cnt_reg : bqe_pkg::TAP_B0;
    assign raddr  = CA_W'(int'(ch_idx) * bqe_pkg::TAPS + int'(rd_tap));
    assign accept = in_valid && in_ready;
    assign finish = (state_reg == ST_RUN) && (cnt_reg == LAST_STEP);

    bqe_ram #(
        .WIDTH (bqe_pkg::COEF_W),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_wr.en),
        .waddr (coef_wr.addr[CA_W-1:0]),
        .wdata (coef_wr.data),
        .raddr (raddr),
        .rdata (coef_rd)
    );

    // a slot never written keeps the identity section
    always_comb
    begin
        if (cvalid_rd_reg)
        begin
            coef_eff = coef_rd;
        end
        else if (tap_mul_reg == bqe_pkg::TAP_B0)
        begin
            coef_eff = bqe_pkg::COEF_ONE;
        end
        else
        begin
            coef_eff = '0;
        end
    end

    always_comb
    begin
        case (tap_mul_reg)
            bqe_pkg::TAP_B0: operand = item_reg.sample;
            bqe_pkg::TAP_B1: operand = x1_reg[ch_idx];
            bqe_pkg::TAP_B2: operand = x2_reg[ch_idx];
            bqe_pkg::TAP_A1: operand = y1_reg[ch_idx];
            bqe_pkg::TAP_A2: operand = y2_reg[ch_idx];
            default:         operand = '0;
        endcase
    end

    assign prod_next = coef_eff * operand;

    // each tap: coefficient read, registered product, then accumulation
    always_comb
    begin
        term = {{(bqe_pkg::ACC_W - bqe_pkg::PROD_W){prod_reg[bqe_pkg::PROD_W-1]}}, prod_reg};
        if (neg_reg)
        begin
            term = -term;
        end
        acc_next = acc_reg;
        if (state_reg == ST_RUN)
        begin
            if (cnt_reg == 3'd2)
            begin
                acc_next = term;
            end
            else if (cnt_reg inside {[3'd3:3'd6]})
            begin
                acc_next = acc_reg + term;
            end
        end
    end

    // floor(acc / 2^20 + 1/2), then clamp to Q1.23
    always_comb
    begin
        rnd    = acc_reg + ROUND_HALF;
        y_wide = $signed(rnd[bqe_pkg::ACC_W-1:bqe_pkg::FRAC_W]);
        sat    = 1'b0;
        y_sat  = y_wide[SW-1:0];
        if (y_wide > Y_MAX)
        begin
            y_sat = Y_MAX[SW-1:0];
            sat   = 1'b1;
        end
        else if (y_wide < Y_MIN)
        begin
            y_sat = Y_MIN[SW-1:0];
            sat   = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_word.bypass ? ST_DONE : ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign out_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            coef_valid_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                x1_reg[c] <= '0;
                x2_reg[c] <= '0;
                y1_reg[c] <= '0;
                y2_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (coef_wr.en)
            begin
                coef_valid_reg[coef_wr.addr[CA_W-1:0]] <= 1'b1;
            end
            if (finish)
            begin
                x2_reg[ch_idx] <= x1_reg[ch_idx];
                x1_reg[ch_idx] <= item_reg.sample;
                y2_reg[ch_idx] <= y1_reg[ch_idx];
                y1_reg[ch_idx] <= y_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cvalid_rd_reg <= coef_valid_reg[raddr];
        tap_mul_reg   <= rd_tap;
        prod_reg      <= prod_next;
        neg_reg       <= (tap_mul_reg == bqe_pkg::TAP_A1) || (tap_mul_reg == bqe_pkg::TAP_A2);
        acc_reg       <= acc_next;
        if (accept)
        begin
            item_reg <= in_word;
            if (in_word.bypass)
            begin
                out_reg <= in_word;
            end
        end
        if (finish)
        begin
            out_reg.chan   <= item_reg.chan;
            out_reg.sample <= y_sat;
            out_reg.clip   <= item_reg.clip | sat;
            out_reg.bypass <= 1'b0;
        end
    end

    a_finish_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (state_reg == ST_DONE))
        else $error("section did not present its result after the last step");

    a_run_not_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !item_reg.bypass)
        else $error("pass-through word entered the MAC sequence");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_word))
        else $error("section result changed while stalled");

endmodule

/* rtl/biquad_cascade_equalizer.sv */
// Top level of the multichannel biquad cascade equalizer.
// Depends on bqe_pkg, bqe_if (bqe_in_if, bqe_out_if) and bqe_cell.
//
// Usage:
//   samples  : input words {channel_in, sample_in}, valid/ready.
//   filtered : output words {channel_out, sample_out, clipped}, valid/ready.
//   cfg_*    : write port. Index REG_COEF_ADDRESS sets the table slot,
//              index REG_COEF_WORD stores cfg_data into that slot. The slot
//              (channel*SECTIONS + section)*5 + tap is decoded, and the write
//              is registered before it reaches one section's local coefficient RAM.
// Each section is a cell with one multiplier that walks its five taps:
// coefficient read, product, accumulate, then round and clamp; only then can
// the next cell take the word. Cells work on different words at once, but a
// cell takes a new word only after it has handed its last one on and gone
// back to idle. A channel beyond CHANNELS passes straight through. After
// reset all history is zero and every section is identity. A stalled receiver
// holds the word in the last cell and the stall backs up cell by cell.
module biquad_cascade_equalizer #(
    parameter int CHANNELS = 2,
    parameter int SECTIONS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bqe_in_if.sink                            samples,
    bqe_out_if.source                         filtered,
    input  logic                              cfg_write,
    input  logic [bqe_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bqe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CH_W        = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int SEC_W       = SECTIONS > 1 ? $clog2(SECTIONS) : 1;
    localparam int TABLE_DEPTH = CHANNELS * SECTIONS * bqe_pkg::TAPS;

    logic [bqe_pkg::ADDR_W-1:0] coef_address_reg;

    logic [14:0]      div_prod;
    logic [4:0]       biquad;
    logic [2:0]       tap;
    logic [CH_W-1:0]  ch;
    logic [SEC_W-1:0] sec;
    logic             in_range;

    bqe_pkg::bqe_coef_wr_t wr_reg, wr_next;
    logic [SEC_W-1:0]      sec_reg;

    bqe_pkg::bqe_coef_wr_t cell_wr [SECTIONS];
    logic [SECTIONS-1:0]   cell_en;

    logic               chain_valid [SECTIONS+1];
    logic               chain_ready [SECTIONS+1];
    bqe_pkg::bqe_word_t chain_word  [SECTIONS+1];

    // slot / 5 for a 7-bit slot: exact as (slot * 205) >> 10
    assign div_prod = {8'b0, coef_address_reg} * 15'd205;
    assign biquad   = div_prod[14:10];
    assign tap      = 3'(coef_address_reg - 7'(biquad) * 7'd5);
    assign in_range = 32'(coef_address_reg) < 32'(TABLE_DEPTH);

    always_comb
    begin
        ch = '0;
        for (int c = 1; c < CHANNELS; c++)
        begin
            if (int'(biquad) >= c * SECTIONS)
            begin
                ch = CH_W'(c);
            end
        end
    end

    assign sec = SEC_W'(int'(biquad) - int'(ch) * SECTIONS);

    always_comb
    begin
        wr_next.en   = cfg_write && (cfg_index == bqe_pkg::REG_COEF_WORD) && in_range;
        wr_next.addr = bqe_pkg::LOCAL_ADDR_W'(int'(ch) * bqe_pkg::TAPS + int'(tap));
        wr_next.data = $signed(cfg_data[bqe_pkg::COEF_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_address_reg <= '0;
            wr_reg           <= '0;
            sec_reg          <= '0;
        end
        else
        begin
            if (cfg_write && (cfg_index == bqe_pkg::REG_COEF_ADDRESS))
            begin
                coef_address_reg <= cfg_data[bqe_pkg::ADDR_W-1:0];
            end
            wr_reg  <= wr_next;
            sec_reg <= sec;
        end
    end

    always_comb
    begin
        chain_valid[0]       = samples.valid;
        chain_word[0].chan   = samples.channel_in;
        chain_word[0].sample = samples.sample_in;
        chain_word[0].clip   = 1'b0;
        chain_word[0].bypass = 32'(samples.channel_in) >= 32'(CHANNELS);
    end

    assign samples.ready        = chain_ready[0];
    assign filtered.valid       = chain_valid[SECTIONS];
    assign chain_ready[SECTIONS] = filtered.ready;
    assign filtered.channel_out = chain_word[SECTIONS].chan;
    assign filtered.sample_out  = chain_word[SECTIONS].sample;
    assign filtered.clipped     = chain_word[SECTIONS].clip;

    for (genvar s = 0; s < SECTIONS; s++)
    begin : g_sec
        assign cell_en[s]      = wr_reg.en && (sec_reg == SEC_W'(s));
        assign cell_wr[s].en   = cell_en[s];
        assign cell_wr[s].addr = wr_reg.addr;
        assign cell_wr[s].data = wr_reg.data;

        bqe_cell #(
            .CHANNELS (CHANNELS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .coef_wr   (cell_wr[s]),
            .in_valid  (chain_valid[s]),
            .in_ready  (chain_ready[s]),
            .in_word   (chain_word[s]),
            .out_valid (chain_valid[s+1]),
            .out_ready (chain_ready[s+1]),
            .out_word  (chain_word[s+1])
        );
    end

    a_one_section_written: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_en))
        else $error("coefficient write decoded to more than one section");

endmodule
